// ===== rtl/nalsplit_pkg.sv =====
// shared types and constants for the annex b nal unit splitter
package nalsplit_pkg;

  localparam int MAX_PACKET_BYTES = 1048576;
  localparam int BYTE_W = 8;
  localparam int TYPE_W = 5;
  localparam int POS_W  = 20;
  localparam int LEN_W  = 21;
  localparam int RUN_W  = 2;

  localparam logic [LEN_W-1:0] LEN_CAP =
    (MAX_PACKET_BYTES > (2**LEN_W) - 1) ? {LEN_W{1'b1}} : LEN_W'(MAX_PACKET_BYTES);

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;
  localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;
  localparam logic [TYPE_W-1:0] NAL_SEI    = 5'd6;
  localparam logic [RUN_W-1:0]  RUN_MAX    = 2'd3;
  localparam logic [RUN_W-1:0]  RUN_START  = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0] nal_type;
    logic [POS_W-1:0]  nal_offset;
    logic [LEN_W-1:0]  nal_size;
    logic              packet_end;
  } nal_result_t;

endpackage

// ===== rtl/annexb_nal_unit_splitter_top.sv =====
// top level of the annex b nal unit splitter
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready    data_byte, last_byte
// out      output     out_valid / out_ready  nal_type, nal_offset, nal_size, packet_end
// cfg      input      cfg_write_en           cfg_write_data (skip_sei)
//
// one byte per cycle while out_ready is high; a byte is held in the input register, and
// the scan registers its unit result in the result register when it takes the byte
// a byte passes the input register and then the result register before out_valid rises
// rst is synchronous; it clears the scan state and sets skip_sei to 1
// a stalled out_ready holds the result and backs up through in_ready
module annexb_nal_unit_splitter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic                                cfg_write_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [nalsplit_pkg::BYTE_W-1:0]     data_byte,
  input  logic                                last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [nalsplit_pkg::TYPE_W-1:0]     nal_type,
  output logic [nalsplit_pkg::POS_W-1:0]      nal_offset,
  output logic [nalsplit_pkg::LEN_W-1:0]      nal_size,
  output logic                                packet_end
);

  nalsplit_pkg::in_item_t     in_item;
  nalsplit_pkg::in_item_t     item;
  logic                       item_valid;
  logic                       item_ready;
  nalsplit_pkg::nal_result_t  result;

  assign in_item.data_byte = data_byte;
  assign in_item.last_byte = last_byte;

  nalsplit_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  nalsplit_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result         (result)
  );

  assign nal_type   = result.nal_type;
  assign nal_offset = result.nal_offset;
  assign nal_size   = result.nal_size;
  assign packet_end = result.packet_end;

endmodule

// ===== rtl/nalsplit_in_reg.sv =====
// input register holding one accepted byte transaction
module nalsplit_in_reg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  nalsplit_pkg::in_item_t   in_item,
  output logic                     item_valid,
  input  logic                     item_ready,
  output nalsplit_pkg::in_item_t   item
);

  logic item_valid_next;

  assign in_ready = !item_valid || item_ready;

  always_comb begin
    item_valid_next = item_valid;
    if (in_ready) begin
      item_valid_next = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/nalsplit_scan.sv =====
// start code scan, unit tracking and result register
module nalsplit_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic                        cfg_write_data,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  nalsplit_pkg::in_item_t      item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output nalsplit_pkg::nal_result_t   result
);

  logic                                skip_sei;
  logic [nalsplit_pkg::RUN_W-1:0]      zero_run, zero_run_next;
  logic                                in_unit, in_unit_next;
  logic [nalsplit_pkg::POS_W-1:0]      byte_position, byte_position_next;
  logic [nalsplit_pkg::POS_W-1:0]      unit_start, unit_start_next;
  logic [nalsplit_pkg::LEN_W-1:0]      unit_length, unit_length_next;
  logic [nalsplit_pkg::TYPE_W-1:0]     unit_kind, unit_kind_next;
  logic                                out_valid_next;

  logic                                consume;
  logic                                is_start;
  logic [nalsplit_pkg::LEN_W-1:0]      run_ext;
  logic [nalsplit_pkg::LEN_W-1:0]      start_size;
  logic [nalsplit_pkg::LEN_W-1:0]      len_inc;
  logic [nalsplit_pkg::TYPE_W-1:0]     kind_new;
  logic                                emit_start, emit_end, emit;
  nalsplit_pkg::nal_result_t           res_next;

  assign item_ready = !out_valid || out_ready;
  assign consume    = item_valid && item_ready;

  always_comb begin
    is_start   = (item.data_byte == nalsplit_pkg::START_BYTE) &&
                 (zero_run >= nalsplit_pkg::RUN_START);
    run_ext    = nalsplit_pkg::LEN_W'(zero_run);
    start_size = (unit_length >= run_ext) ? (unit_length - run_ext) : '0;
    len_inc    = unit_length;
    if (in_unit && (unit_length < nalsplit_pkg::LEN_CAP)) begin
      len_inc = unit_length + nalsplit_pkg::LEN_W'(1);
    end
    kind_new = unit_kind;
    if (in_unit && (unit_length == '0)) begin
      kind_new = item.data_byte[nalsplit_pkg::TYPE_W-1:0];
    end

    emit_start = is_start && in_unit && (start_size != '0) &&
                 !(skip_sei && (unit_kind == nalsplit_pkg::NAL_SEI));
    emit_end   = !is_start && item.last_byte && in_unit && (len_inc != '0) &&
                 !(skip_sei && (kind_new == nalsplit_pkg::NAL_SEI));
    emit       = emit_start || emit_end;

    res_next.nal_offset = unit_start;
    if (is_start) begin
      res_next.nal_type   = unit_kind;
      res_next.nal_size   = start_size;
      res_next.packet_end = 1'b0;
    end else begin
      res_next.nal_type   = kind_new;
      res_next.nal_size   = len_inc;
      res_next.packet_end = 1'b1;
    end

    byte_position_next = byte_position + nalsplit_pkg::POS_W'(1);
    if (is_start) begin
      in_unit_next     = 1'b1;
      unit_start_next  = byte_position + nalsplit_pkg::POS_W'(1);
      unit_length_next = '0;
      unit_kind_next   = '0;
      zero_run_next    = '0;
    end else begin
      in_unit_next     = in_unit;
      unit_start_next  = unit_start;
      unit_length_next = len_inc;
      unit_kind_next   = kind_new;
      if (item.data_byte == nalsplit_pkg::ZERO_BYTE) begin
        zero_run_next = (zero_run < nalsplit_pkg::RUN_MAX) ?
                        zero_run + nalsplit_pkg::RUN_W'(1) : nalsplit_pkg::RUN_MAX;
      end else begin
        zero_run_next = '0;
      end
    end
    if (item.last_byte) begin
      byte_position_next = '0;
      in_unit_next       = 1'b0;
      unit_start_next    = '0;
      unit_length_next   = '0;
      unit_kind_next     = '0;
      zero_run_next      = '0;
    end

    out_valid_next = out_valid;
    if (consume) begin
      out_valid_next = emit;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_sei      <= 1'b1;
      zero_run      <= '0;
      in_unit       <= 1'b0;
      byte_position <= '0;
      unit_start    <= '0;
      unit_length   <= '0;
      unit_kind     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        skip_sei <= cfg_write_data;
      end
      if (consume) begin
        zero_run      <= zero_run_next;
        in_unit       <= in_unit_next;
        byte_position <= byte_position_next;
        unit_start    <= unit_start_next;
        unit_length   <= unit_length_next;
        unit_kind     <= unit_kind_next;
      end
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      result <= res_next;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench for the annex b nal unit splitter: byte streams in, nal unit records checked
`timescale 1ns / 1ps

module tb_top;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int ERROR_PRINTS  = 40;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_write_en = 1'b0;
  logic                              cfg_write_data = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [nalsplit_pkg::BYTE_W-1:0]   data_byte = '0;
  logic                              last_byte = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b1;
  logic [nalsplit_pkg::TYPE_W-1:0]   nal_type;
  logic [nalsplit_pkg::POS_W-1:0]    nal_offset;
  logic [nalsplit_pkg::LEN_W-1:0]    nal_size;
  logic                              packet_end;

  // splitter state as the scan sees it
  logic [nalsplit_pkg::RUN_W-1:0]    zero_count = '0;
  logic                              have_unit = 1'b0;
  logic [nalsplit_pkg::POS_W-1:0]    next_pos = '0;
  logic [nalsplit_pkg::POS_W-1:0]    unit_base = '0;
  logic [nalsplit_pkg::LEN_W-1:0]    unit_len = '0;
  logic [nalsplit_pkg::TYPE_W-1:0]   unit_type = '0;
  logic                              sei_skip = 1'b1;

  nalsplit_pkg::nal_result_t         nal_expect_q [$];
  nalsplit_pkg::nal_result_t         nal_head;
  int                                mismatches = 0;
  int                                cycles = 0;
  int                                stream_bytes = 0;
  int                                stall_left = 0;
  bit                                bursty = 1'b0;

  always #2ns clk = ~clk;

  annexb_nal_unit_splitter_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .nal_type       (nal_type),
    .nal_offset     (nal_offset),
    .nal_size       (nal_size),
    .packet_end     (packet_end)
  );

  function automatic bit close_nal(input logic [nalsplit_pkg::LEN_W-1:0] size,
                                   input logic at_end,
                                   output nalsplit_pkg::nal_result_t rec);
    rec.nal_type   = unit_type;
    rec.nal_offset = unit_base;
    rec.nal_size   = size;
    rec.packet_end = at_end;
    return (size != '0) && !(sei_skip && unit_type == nalsplit_pkg::NAL_SEI);
  endfunction

  function automatic bit scan_byte(input logic [nalsplit_pkg::BYTE_W-1:0] b, input logic lst,
                                   output nalsplit_pkg::nal_result_t rec);
    bit hit;
    logic [nalsplit_pkg::POS_W-1:0] pos;
    logic [nalsplit_pkg::LEN_W-1:0] run_len;
    hit = 1'b0;
    pos = next_pos;
    rec = '0;
    run_len = nalsplit_pkg::LEN_W'(zero_count);
    if (b == nalsplit_pkg::START_BYTE && zero_count >= nalsplit_pkg::RUN_START) begin
      if (have_unit) begin
        hit = close_nal((unit_len >= run_len) ? unit_len - run_len : '0, 1'b0, rec);
      end
      have_unit  = 1'b1;
      unit_base  = pos + nalsplit_pkg::POS_W'(1);
      unit_len   = '0;
      unit_type  = '0;
      zero_count = '0;
    end else begin
      if (have_unit) begin
        if (unit_len == '0) unit_type = b[nalsplit_pkg::TYPE_W-1:0];
        if (unit_len < nalsplit_pkg::LEN_CAP) unit_len = unit_len + nalsplit_pkg::LEN_W'(1);
      end
      if (b == nalsplit_pkg::ZERO_BYTE)
        zero_count = (zero_count < nalsplit_pkg::RUN_MAX) ?
                     zero_count + nalsplit_pkg::RUN_W'(1) : nalsplit_pkg::RUN_MAX;
      else zero_count = '0;
    end
    next_pos = pos + nalsplit_pkg::POS_W'(1);
    if (lst) begin
      if (!hit && have_unit) hit = close_nal(unit_len, 1'b1, rec);
      zero_count = '0;
      have_unit  = 1'b0;
      next_pos   = '0;
      unit_base  = '0;
      unit_len   = '0;
      unit_type  = '0;
    end
    return hit;
  endfunction

  function automatic void field_check(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= ERROR_PRINTS)
        $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (nal_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ERROR_PRINTS)
          $error("unexpected transaction: nal_type %0d nal_offset %0d nal_size %0d",
                 nal_type, nal_offset, nal_size);
      end else begin
        nal_head = nal_expect_q.pop_front();
        field_check("nal_type", nal_head.nal_type, nal_type);
        field_check("nal_offset", nal_head.nal_offset, nal_offset);
        field_check("nal_size", nal_head.nal_size, nal_size);
        field_check("packet_end", nal_head.packet_end, packet_end);
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (bursty && $urandom_range(0, 6) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready  <= 1'b1;
    end
  end

  task automatic push_byte(input logic [nalsplit_pkg::BYTE_W-1:0] b, input logic lst);
    int gap;
    nalsplit_pkg::nal_result_t rec;
    gap = (bursty && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (!in_ready);
    stream_bytes++;
    if (scan_byte(b, lst, rec)) nal_expect_q.push_back(rec);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (nal_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_skip_sei(input logic v);
    wait_quiet();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    sei_skip = v;
  endtask

  task automatic send_packet(input logic [nalsplit_pkg::BYTE_W-1:0] pkt [$],
                             input bit pause_mid);
    for (int i = 0; i < pkt.size(); i++) begin
      if (pause_mid && i == pkt.size() / 2) wait_quiet();
      push_byte(pkt[i], i == pkt.size() - 1);
    end
  endtask

  function automatic logic [nalsplit_pkg::BYTE_W-1:0] body_byte();
    return ($urandom_range(0, 5) == 0) ? nalsplit_pkg::ZERO_BYTE :
           nalsplit_pkg::BYTE_W'($urandom_range(2, 255));
  endfunction

  function automatic void build_stream_packet(ref logic [nalsplit_pkg::BYTE_W-1:0] pkt [$]);
    int units;
    int zeros;
    pkt.delete();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) pkt.push_back(nalsplit_pkg::BYTE_W'($urandom));
    units = $urandom_range(1, 4);
    repeat (units) begin
      zeros = 2 + $urandom_range(0, 1);
      if ($urandom_range(0, 7) == 0) zeros += $urandom_range(1, 3);
      repeat (zeros) pkt.push_back(nalsplit_pkg::ZERO_BYTE);
      pkt.push_back(nalsplit_pkg::START_BYTE);
      if ($urandom_range(0, 7) != 0) begin
        if ($urandom_range(0, 3) == 0)
          pkt.push_back({nalsplit_pkg::BYTE_W'($urandom_range(0, 7)) << nalsplit_pkg::TYPE_W} |
                        nalsplit_pkg::BYTE_W'(nalsplit_pkg::NAL_SEI));
        else
          pkt.push_back(nalsplit_pkg::BYTE_W'($urandom));
        repeat ($urandom_range(0, 10)) pkt.push_back(body_byte());
      end
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) pkt.push_back(nalsplit_pkg::ZERO_BYTE);
    if ($urandom_range(0, 7) == 0) begin
      pkt.push_back(nalsplit_pkg::ZERO_BYTE);
      pkt.push_back(nalsplit_pkg::ZERO_BYTE);
      pkt.push_back(nalsplit_pkg::START_BYTE);
    end
  endfunction

  function automatic void build_noise_packet(ref logic [nalsplit_pkg::BYTE_W-1:0] pkt [$]);
    int pick;
    pkt.delete();
    repeat ($urandom_range(1, 12)) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) pkt.push_back(nalsplit_pkg::ZERO_BYTE);
      else if (pick < 6) pkt.push_back(nalsplit_pkg::START_BYTE);
      else pkt.push_back(nalsplit_pkg::BYTE_W'($urandom));
    end
  endfunction

  task automatic test_start_codes();
    logic [nalsplit_pkg::BYTE_W-1:0] pkt [$];
    pkt = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h06, 8'hAA,
            8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'hE5,
            8'h00, 8'h00, 8'h01};
    send_packet(pkt, 1'b0);
  endtask

  task automatic test_packet_edges();
    logic [nalsplit_pkg::BYTE_W-1:0] pkt [$];
    pkt = '{8'h00, 8'h00, 8'h01, 8'h00};
    send_packet(pkt, 1'b0);
    pkt = '{8'h7C};
    send_packet(pkt, 1'b0);
  endtask

  task automatic test_sei_passthrough();
    logic [nalsplit_pkg::BYTE_W-1:0] pkt [$];
    set_skip_sei(1'b0);
    pkt = '{8'h00, 8'h00, 8'h01, 8'h06, 8'h05, 8'h00, 8'h00, 8'h00, 8'h01, 8'h26, 8'h01};
    send_packet(pkt, 1'b0);
    set_skip_sei(1'b1);
    send_packet(pkt, 1'b0);
  endtask

  // a long unit closed by a start code, then a unit closed by the packet end
  task automatic test_long_packet();
    bursty = 1'b0;
    push_byte(nalsplit_pkg::ZERO_BYTE, 1'b0);
    push_byte(nalsplit_pkg::ZERO_BYTE, 1'b0);
    push_byte(nalsplit_pkg::START_BYTE, 1'b0);
    push_byte(8'h45, 1'b0);
    repeat (64) push_byte(nalsplit_pkg::BYTE_W'($urandom_range(2, 255)), 1'b0);
    push_byte(nalsplit_pkg::ZERO_BYTE, 1'b0);
    push_byte(nalsplit_pkg::ZERO_BYTE, 1'b0);
    push_byte(nalsplit_pkg::START_BYTE, 1'b0);
    push_byte(8'h21, 1'b0);
    push_byte(8'h33, 1'b1);
    wait_quiet();
  endtask

  task automatic test_random_streams(input int items, input logic skip, input bit with_idle);
    logic [nalsplit_pkg::BYTE_W-1:0] pkt [$];
    int stop_at;
    set_skip_sei(skip);
    stop_at = stream_bytes + items;
    while (stream_bytes < stop_at) begin
      bursty = with_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) build_noise_packet(pkt);
      else build_stream_packet(pkt);
      send_packet(pkt, $urandom_range(0, 29) == 0);
    end
    bursty = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    bursty = 1'b1;
    test_start_codes();
    test_packet_edges();
    test_sei_passthrough();
    test_long_packet();
    test_random_streams(350, 1'b1, 1'b1);
    test_random_streams(350, 1'b0, 1'b1);
    test_random_streams(350, logic'($urandom_range(0, 1)), 1'b1);
    test_random_streams(350, 1'b1, 1'b0);
    wait_quiet();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
